### hw/rtl/circular_deque_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular deque
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef SYNTH
`define CDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Command and status codes and the input and result word types.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [31:0] WORD_EMPTY = -32'sd1;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               is_empty_flag;
        logic               is_full_flag;
    } t_out_word;

endpackage

### hw/rtl/cdq_ring.sv
// ----------------------------------------------------------------------------
// Circular deque ring store
// One write port and two read ports with registered read data and
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module cdq_ring #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic signed [31:0]       i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic signed [31:0]       o_rd_data_a,
    output logic signed [31:0]       o_rd_data_b
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
            r_rd_a <= i_wr_data;
        end else begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
            r_rd_b <= i_wr_data;
        end else begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### hw/rtl/cdq_core.sv
// ----------------------------------------------------------------------------
// Circular deque core
// Head and tail indices, cached end words and the result of one command.
// ----------------------------------------------------------------------------
module cdq_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_word  i_in_word,
    output t_out_word o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : IW'(i + 1'b1);
    endfunction

    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
        return (i == '0) ? LAST_IDX : IW'(i - 1'b1);
    endfunction

    logic [IW-1:0]      r_head, n_head, upd_head;
    logic [IW-1:0]      r_tail, n_tail, upd_tail;
    logic               r_empty, n_empty, upd_empty;
    logic signed [31:0] r_front, n_front, upd_front;
    logic signed [31:0] r_back, n_back, upd_back;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] second_front;
    logic signed [31:0] second_back;
    logic signed [31:0] popped;
    logic [1:0]         status;
    logic               is_push;
    logic               is_pop;
    logic               full_now;

    cdq_ring #(
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_in_word.value),
        .i_rd_addr_a (idx_next(n_head)),
        .i_rd_addr_b (idx_prev(n_tail)),
        .o_rd_data_a (second_front),
        .o_rd_data_b (second_back)
    );

    always_comb begin
        is_push   = (i_in_word.cmd == CMD_PUSH_FRONT) || (i_in_word.cmd == CMD_PUSH_BACK);
        is_pop    = (i_in_word.cmd == CMD_POP_FRONT) || (i_in_word.cmd == CMD_POP_BACK);
        full_now  = !r_empty && (idx_next(r_tail) == r_head);
        upd_head  = r_head;
        upd_tail  = r_tail;
        upd_empty = r_empty;
        upd_front = r_front;
        upd_back  = r_back;
        wr_en     = 1'b0;
        wr_addr   = r_head;
        popped    = '0;
        status    = ST_DONE;
        if (is_push) begin
            if (full_now) begin
                status = ST_FULL;
            end else if (r_empty) begin
                upd_head  = '0;
                upd_tail  = '0;
                upd_empty = 1'b0;
                upd_front = i_in_word.value;
                upd_back  = i_in_word.value;
                wr_en     = 1'b1;
                wr_addr   = '0;
            end else if (i_in_word.cmd == CMD_PUSH_FRONT) begin
                upd_head  = idx_prev(r_head);
                upd_front = i_in_word.value;
                wr_en     = 1'b1;
                wr_addr   = idx_prev(r_head);
            end else begin
                upd_tail = idx_next(r_tail);
                upd_back = i_in_word.value;
                wr_en    = 1'b1;
                wr_addr  = idx_next(r_tail);
            end
        end else if (is_pop) begin
            if (r_empty) begin
                status = ST_EMPTY;
            end else begin
                popped = (i_in_word.cmd == CMD_POP_FRONT) ? r_front : r_back;
                if (r_head == r_tail) begin
                    upd_empty = 1'b1;
                    upd_head  = '0;
                    upd_tail  = '0;
                end else if (i_in_word.cmd == CMD_POP_FRONT) begin
                    upd_head  = idx_next(r_head);
                    upd_front = second_front;
                end else begin
                    upd_tail = idx_prev(r_tail);
                    upd_back = second_back;
                end
            end
        end
        wr_en = wr_en && i_go;

        n_head  = i_go ? upd_head : r_head;
        n_tail  = i_go ? upd_tail : r_tail;
        n_empty = i_go ? upd_empty : r_empty;
        n_front = i_go ? upd_front : r_front;
        n_back  = i_go ? upd_back : r_back;

        o_result.popped_value  = popped;
        o_result.status        = status;
        o_result.front_value   = upd_empty ? WORD_EMPTY : upd_front;
        o_result.back_value    = upd_empty ? WORD_EMPTY : upd_back;
        o_result.is_empty_flag = upd_empty;
        o_result.is_full_flag  = !upd_empty && (idx_next(upd_tail) == upd_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_back  <= n_back;
    end

endmodule

### hw/rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// Circular deque
// The input and result registers set the throughput and each hold one word.
// Throughput: one word per cycle unless the output stalls.
// Reset: synchronous, active low; the deque comes up empty at once with no
// clearing pass, and the ring store contents stay undefined until written.
// ----------------------------------------------------------------------------
`include "circular_deque_assert.svh"

module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_valid, n_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      advance;
    logic      in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    cdq_core #(
        .DEPTH(DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (advance),
        .i_in_word (r_in_word),
        .o_result  (result)
    );

    always_comb begin
        n_in_valid  = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `CDQ_ASSERT(a_flags_excl,
        !o_out_valid || !(o_out_word.is_empty_flag && o_out_word.is_full_flag),
        "empty and full both set")
    `CDQ_ASSERT(a_empty_reads,
        !o_out_valid || !o_out_word.is_empty_flag ||
        ((o_out_word.front_value == WORD_EMPTY) && (o_out_word.back_value == WORD_EMPTY)),
        "empty deque shows end words")
    `CDQ_ASSERT(a_reject_flags,
        !o_out_valid || ((o_out_word.status != ST_FULL || o_out_word.is_full_flag) &&
        (o_out_word.status != ST_EMPTY ||
        (o_out_word.is_empty_flag && o_out_word.popped_value == 32'sd0))),
        "rejected command with wrong flags")
    `CDQ_ASSERT_NEXT(a_advance_out, advance, o_out_valid, "advanced word missing at output")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular deque testbench
// Sends push, pop and query words to the deque with random idle and stall
// bursts on both sides. Each result word is checked against an in-bench
// model of the ring store, its indices and the empty mark.
// ----------------------------------------------------------------------------
module testbench;
    import cdq_pkg::*;

    localparam int DEPTH = 128;
    localparam int RANDOM_WORDS = 1550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_WORDS = 200;

    localparam logic [2:0] CMD_QUERY     = 3'd4;
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    localparam logic signed [31:0] WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_ZERO = 32'sh0000_0000;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mix_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    logic signed [31:0] ring_model [DEPTH];
    int head_idx = 0;
    int tail_idx = 0;
    bit deque_empty = 1'b1;

    int  errors = 0;
    int  words_queued = 0;
    int  words_taken = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  calm_left = 0;
    bit  calm = 1'b0;
    bit  settle = 1'b0;

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int wrap_next(int i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic int wrap_prev(int i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function automatic bit deque_full();
        return !deque_empty && wrap_next(tail_idx) == head_idx;
    endfunction

    function automatic t_out_word apply_command(t_in_word w);
        t_out_word r;
        r = '0;
        r.status = ST_DONE;
        case (w.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (deque_full()) begin
                    r.status = ST_FULL;
                end else if (deque_empty) begin
                    head_idx = 0;
                    tail_idx = 0;
                    deque_empty = 1'b0;
                    ring_model[0] = w.value;
                end else if (w.cmd == CMD_PUSH_FRONT) begin
                    head_idx = wrap_prev(head_idx);
                    ring_model[head_idx] = w.value;
                end else begin
                    tail_idx = wrap_next(tail_idx);
                    ring_model[tail_idx] = w.value;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (deque_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = (w.cmd == CMD_POP_FRONT) ? ring_model[head_idx]
                                                              : ring_model[tail_idx];
                    if (head_idx == tail_idx) begin
                        deque_empty = 1'b1;
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (w.cmd == CMD_POP_FRONT) begin
                        head_idx = wrap_next(head_idx);
                    end else begin
                        tail_idx = wrap_prev(tail_idx);
                    end
                end
            end
            default: begin
            end
        endcase
        r.front_value   = deque_empty ? WORD_EMPTY : ring_model[head_idx];
        r.back_value    = deque_empty ? WORD_EMPTY : ring_model[tail_idx];
        r.is_empty_flag = deque_empty;
        r.is_full_flag  = deque_full();
        return r;
    endfunction

    function automatic int pick_gap();
        if (calm || settle) begin
            return 0;
        end
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(1, 7);
        end
        return 0;
    endfunction

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 11))
            0: begin
                return WORD_MAX;
            end
            1: begin
                return WORD_MIN;
            end
            2: begin
                return WORD_ZERO;
            end
            3: begin
                return WORD_EMPTY;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic queue_word(logic [2:0] cmd, logic signed [31:0] value);
        t_in_word w;
        w.cmd = cmd;
        w.value = value;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    task automatic check_result(t_out_word got);
        t_out_word want;
        if (expected_results.size() == 0) begin
            $display("%0t unexpected result word %h", $time, got);
            errors++;
        end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got.popped_value !== want.popped_value) begin
                $display("%0t popped_value expected %0d got %0d",
                         $time, want.popped_value, got.popped_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.front_value !== want.front_value) begin
                $display("%0t front_value expected %0d got %0d",
                         $time, want.front_value, got.front_value);
                errors++;
            end
            if (got.back_value !== want.back_value) begin
                $display("%0t back_value expected %0d got %0d",
                         $time, want.back_value, got.back_value);
                errors++;
            end
            if (got.is_empty_flag !== want.is_empty_flag) begin
                $display("%0t is_empty_flag expected %0d got %0d",
                         $time, want.is_empty_flag, got.is_empty_flag);
                errors++;
            end
            if (got.is_full_flag !== want.is_full_flag) begin
                $display("%0t is_full_flag expected %0d got %0d",
                         $time, want.is_full_flag, got.is_full_flag);
                errors++;
            end
        end
    endtask

    // Alternate between stretches with idling allowed and stretches without it.
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(30, 300);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Input driver.
    always @(posedge i_clk) begin
        int  n;
        bit  holding;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_word <= '0;
        end else begin
            holding = in_valid;
            if (in_valid && !in_stall) begin
                expected_results.insert(expected_results.size(), apply_command(in_word));
                words_taken++;
                holding = 1'b0;
            end
            settle = (pending_words.size() < SETTLE_WORDS);
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else begin
                    n = pick_gap();
                    if (n > 0) begin
                        gap_left = n - 1;
                        in_valid <= 1'b0;
                    end else if (pending_words.size() > 0) begin
                        in_word <= pending_words[0];
                        pending_words.delete(0);
                        in_valid <= 1'b1;
                    end else begin
                        in_valid <= 1'b0;
                    end
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                check_result(out_word);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                n = pick_gap();
                stall_left = (n > 0) ? n - 1 : 0;
                out_stall <= (n > 0);
            end
        end
    end

    initial begin
        int        remaining;
        int        seg_len;
        int        roll;
        t_mix_mode mode;
        logic [2:0] push_cmd;
        logic [2:0] pop_cmd;

        // Empty deque: query, pops rejected, then extremes at both ends.
        queue_word(CMD_QUERY, WORD_MAX);
        queue_word(CMD_POP_FRONT, WORD_MIN);
        queue_word(CMD_POP_BACK, WORD_MAX);
        queue_word(CMD_PUSH_FRONT, WORD_MAX);
        queue_word(CMD_PUSH_BACK, WORD_MIN);
        queue_word(CMD_QUERY, WORD_ZERO);
        queue_word(CMD_PUSH_FRONT, WORD_ZERO);
        queue_word(CMD_PUSH_BACK, WORD_EMPTY);
        queue_word(CMD_POP_FRONT, WORD_EMPTY);
        queue_word(CMD_POP_BACK, WORD_ZERO);
        queue_word(CMD_POP_FRONT, WORD_ZERO);
        queue_word(CMD_POP_BACK, WORD_ZERO);
        queue_word(CMD_POP_BACK, WORD_ZERO);
        // The last word leaves through the front, then through the back.
        queue_word(CMD_PUSH_BACK, 32'sh5555_5555);
        queue_word(CMD_POP_FRONT, WORD_ZERO);
        queue_word(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
        queue_word(CMD_POP_BACK, WORD_ZERO);
        // Unused command codes behave as a query.
        queue_word(CMD_SPARE_LO, WORD_MAX);
        queue_word(CMD_PUSH_BACK, 32'sh1234_5678);
        queue_word(CMD_SPARE_MID, WORD_MIN);
        queue_word(CMD_SPARE_HI, WORD_EMPTY);
        queue_word(CMD_POP_FRONT, WORD_ZERO);

        // Segments that lean toward filling, draining, or a balanced mix, so
        // that the deque keeps reaching both full and empty with wrapped indices.
        remaining = RANDOM_WORDS;
        while (remaining > 0) begin
            seg_len = $urandom_range(100, 300);
            if (seg_len > remaining) begin
                seg_len = remaining;
            end
            mode = t_mix_mode'($urandom_range(0, 2));
            for (int k = 0; k < seg_len; k++) begin
                roll = $urandom_range(0, 99);
                push_cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                pop_cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                if (roll >= 94) begin
                    queue_word($urandom_range(0, 1) ? CMD_QUERY
                                                    : 3'($urandom_range(CMD_SPARE_LO,
                                                                        CMD_SPARE_HI)),
                               random_value());
                end else if ((mode == MODE_FILL && roll < 80)
                          || (mode == MODE_DRAIN && roll < 14)
                          || (mode == MODE_MIX && roll < 47)) begin
                    queue_word(push_cmd, random_value());
                end else begin
                    queue_word(pop_cmd, random_value());
                end
            end
            remaining -= seg_len;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken != words_queued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
